### hw/rtl/gtlik_pkg.sv
// Package for the genotype error tip likelihood block: widths, Q-format
// constants, register indexes, letter-distance ROM and the fixed-point multiply.
// No dependencies.
package gtlik_pkg;

   localparam int GENOTYPE_COUNT = 10;
   localparam int HOMO_COUNT     = 4;
   localparam int FRAC_BITS      = 16;
   localparam int RATE_W         = 16;
   localparam int MASK_W         = GENOTYPE_COUNT;
   localparam int IDX_W          = $clog2(GENOTYPE_COUNT);
   localparam int VAL_W          = FRAC_BITS + 1;
   localparam int SUM_W          = VAL_W + 3;
   localparam int CSR_IDX_W      = 4;
   localparam int DIST_W         = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_ERROR_RATE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DROPOUT_RATE   = CSR_IDX_W'(1);

   localparam logic [DIST_W-1:0] DIST_SAME = DIST_W'(0);
   localparam logic [DIST_W-1:0] DIST_ONE  = DIST_W'(1);
   localparam logic [DIST_W-1:0] DIST_TWO  = DIST_W'(2);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GENOTYPE_COUNT - 1);
   localparam logic [IDX_W-1:0] HOMO_LIM = IDX_W'(HOMO_COUNT);

   localparam logic [VAL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   localparam longint ONE2 = longint'(1) << (FRAC_BITS + 1);
   localparam logic [VAL_W-1:0] C3  = VAL_W'((ONE2 + 3) / 6);
   localparam logic [VAL_W-1:0] C6  = VAL_W'((ONE2 + 6) / 12);
   localparam logic [VAL_W-1:0] C8  = VAL_W'((ONE2 + 8) / 16);
   localparam logic [VAL_W-1:0] C38 = VAL_W'((3 * ONE2 + 8) / 16);
   localparam logic [VAL_W-1:0] C12 = VAL_W'((ONE2 + 12) / 24);
   localparam logic [VAL_W-1:0] C2  = VAL_W'((ONE2 + 2) / 4);

   localparam logic [DIST_W-1:0] LETTER_DIST [GENOTYPE_COUNT][GENOTYPE_COUNT] = '{
      '{2'd0, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2},
      '{2'd2, 2'd0, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2},
      '{2'd2, 2'd2, 2'd0, 2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1},
      '{2'd2, 2'd2, 2'd2, 2'd0, 2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd1},
      '{2'd1, 2'd1, 2'd2, 2'd2, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2},
      '{2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0, 2'd1, 2'd1, 2'd2, 2'd1},
      '{2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd0, 2'd2, 2'd1, 2'd1},
      '{2'd2, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd2, 2'd0, 2'd1, 2'd1},
      '{2'd2, 2'd1, 2'd2, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0, 2'd1},
      '{2'd2, 2'd2, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0}
   };

   typedef struct packed {
      logic [IDX_W-1:0]  k;
      logic              homo_k;
      logic              homo_o;
      logic [DIST_W-1:0] letters;
      logic              all_ones;
   } tag_type;

   function automatic logic [VAL_W-1:0] fx_mul(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
      logic [2*VAL_W-1:0] p;
      p = {{VAL_W{1'b0}}, a} * {{VAL_W{1'b0}}, b};
      return p[FRAC_BITS +: VAL_W];
   endfunction

endpackage

### hw/rtl/gtlik_if.sv
// Request, response and register-write channel interfaces for the tip
// likelihood block. Depends on gtlik_pkg.
interface gtlik_req_if import gtlik_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] genotype_mask;

   modport source (output valid, output genotype_mask, input ready);
   modport sink   (input valid, input genotype_mask, output ready);
endinterface

interface gtlik_rsp_if import gtlik_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] genotype_index;
   logic [VAL_W-1:0] likelihood;
   logic             last;

   modport source (output valid, output genotype_index, output likelihood, output last,
                   input ready);
   modport sink   (input valid, input genotype_index, input likelihood, input last,
                   output ready);
endinterface

interface gtlik_csr_if import gtlik_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [RATE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/genotype_error_tip_likelihood.sv
// Channel   Modport  Payload
// req       sink     genotype_mask[9:0]
// rsp       source   genotype_index[3:0], likelihood[16:0] (Q1.16), last
// csr       sink     index[3:0], data[15:0] (0: seq_error_rate, 1: dropout_rate)
//
// One request gives ten responses, one per cycle while the pipeline is not stalled;
// the next request is taken in the cycle the tenth index is issued.
// The issue counter feeds a four-stage pipeline (products, constant products,
// sum, clamp); each stage is registered and the response comes from the clamp stage.
// Reset is synchronous and clears the rates, the issue counter and all valids.
// A stalled response holds its stage; empty stages upstream keep filling.
// Depends on gtlik_pkg and gtlik_if.
module genotype_error_tip_likelihood import gtlik_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   gtlik_req_if.sink   req,
   gtlik_rsp_if.source rsp,
   gtlik_csr_if.sink   csr
);

   logic [RATE_W-1:0] seq_error_rate_ff, seq_error_rate_in;
   logic [RATE_W-1:0] dropout_rate_ff, dropout_rate_in;

   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  obs_ff, obs_in;
   logic              all_ones_ff, all_ones_in;
   logic [IDX_W-1:0]  obs_enc;

   logic              req_fire, issue;
   logic              en1, en2, en3, en4;
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;

   logic [VAL_W-1:0]  e_x, d_x, omd, ome;
   tag_type           s1_tag_in, s1_tag_ff, s2_tag_ff, s3_tag_ff;

   logic [VAL_W-1:0]  s1_ed_ff, s1_pde_ff, s1_pdpe_ff, s1_c6e_ff, s1_d2_ff, s1_ome_ff;
   logic [VAL_W-1:0]  s2_c2ed_ff, s2_c12ed_ff, s2_c38ed_ff, s2_c8ed_ff, s2_c3pde_ff;
   logic [VAL_W-1:0]  s2_pdpe_ff, s2_c6e_ff, s2_d2_ff, s2_ome_ff;

   logic signed [SUM_W-1:0] s3_sum_in, s3_sum_ff;
   logic [VAL_W-1:0]  s4_lh_in, s4_lh_ff;

   // register writes
   assign csr.ready = 1'b1;

   always_comb begin
      seq_error_rate_in = seq_error_rate_ff;
      dropout_rate_in   = dropout_rate_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_SEQ_ERROR_RATE: seq_error_rate_in = csr.data;
            CSR_DROPOUT_RATE:   dropout_rate_in   = csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_error_rate_ff <= '0;
         dropout_rate_ff   <= '0;
      end else begin
         seq_error_rate_ff <= seq_error_rate_in;
         dropout_rate_ff   <= dropout_rate_in;
      end
   end

   // pipeline enables
   assign en4   = !s4_valid_ff || rsp.ready;
   assign en3   = !s3_valid_ff || en4;
   assign en2   = !s2_valid_ff || en3;
   assign en1   = !s1_valid_ff || en2;
   assign issue = busy_ff && en1;

   assign req.ready = !busy_ff || (issue && k_ff == LAST_IDX);
   assign req_fire  = req.valid && req.ready;

   // issue counter
   always_comb begin
      obs_enc = '0;
      for (int i = GENOTYPE_COUNT - 1; i >= 0; i--) begin
         if (req.genotype_mask[i]) obs_enc = IDX_W'(i);
      end
   end

   always_comb begin
      busy_in     = busy_ff;
      k_in        = k_ff;
      obs_in      = obs_ff;
      all_ones_in = all_ones_ff;
      if (issue) begin
         k_in = k_ff + IDX_W'(1);
         if (k_ff == LAST_IDX) busy_in = 1'b0;
      end
      if (req_fire) begin
         busy_in     = 1'b1;
         k_in        = '0;
         obs_in      = obs_enc;
         all_ones_in = (req.genotype_mask == '0) || (req.genotype_mask == '1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      obs_ff      <= obs_in;
      all_ones_ff <= all_ones_in;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= issue;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_valid_ff <= s3_valid_ff;
      end
   end

   // stage 1: rate products
   assign e_x = {{(VAL_W-RATE_W){1'b0}}, seq_error_rate_ff};
   assign d_x = {{(VAL_W-RATE_W){1'b0}}, dropout_rate_ff};
   assign omd = ONE - d_x;
   assign ome = ONE - e_x;

   always_comb begin
      s1_tag_in.k        = k_ff;
      s1_tag_in.homo_k   = k_ff < HOMO_LIM;
      s1_tag_in.homo_o   = obs_ff < HOMO_LIM;
      s1_tag_in.letters  = LETTER_DIST[obs_ff][k_ff];
      s1_tag_in.all_ones = all_ones_ff;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_tag_ff  <= s1_tag_in;
         s1_ed_ff   <= fx_mul(e_x, d_x);
         s1_pde_ff  <= fx_mul(omd, e_x);
         s1_pdpe_ff <= fx_mul(omd, ome);
         s1_c6e_ff  <= fx_mul(C6, e_x);
         s1_d2_ff   <= fx_mul(C2, d_x);
         s1_ome_ff  <= ome;
      end
   end

   // stage 2: constant products
   always_ff @(posedge clock) begin
      if (en2) begin
         s2_tag_ff   <= s1_tag_ff;
         s2_c2ed_ff  <= fx_mul(C2, s1_ed_ff);
         s2_c12ed_ff <= fx_mul(C12, s1_ed_ff);
         s2_c38ed_ff <= fx_mul(C38, s1_ed_ff);
         s2_c8ed_ff  <= fx_mul(C8, s1_ed_ff);
         s2_c3pde_ff <= fx_mul(C3, s1_pde_ff);
         s2_pdpe_ff  <= s1_pdpe_ff;
         s2_c6e_ff   <= s1_c6e_ff;
         s2_d2_ff    <= s1_d2_ff;
         s2_ome_ff   <= s1_ome_ff;
      end
   end

   // stage 3: select and sum
   function automatic logic signed [SUM_W-1:0] sx(input logic [VAL_W-1:0] v);
      return $signed({{(SUM_W-VAL_W){1'b0}}, v});
   endfunction

   always_comb begin
      s3_sum_in = '0;
      if (s2_tag_ff.all_ones) begin
         s3_sum_in = sx(ONE);
      end else begin
         case (s2_tag_ff.letters)
            DIST_SAME: begin
               if (s2_tag_ff.homo_o) s3_sum_in = sx(s2_ome_ff) + sx(s2_c2ed_ff);
               else                  s3_sum_in = sx(s2_pdpe_ff) + sx(s2_c12ed_ff);
            end
            DIST_ONE: begin
               if (s2_tag_ff.homo_k)
                  s3_sum_in = sx(s2_c12ed_ff) + sx(s2_c3pde_ff);
               else if (s2_tag_ff.homo_o)
                  s3_sum_in = sx(s2_d2_ff) + sx(s2_c6e_ff) - sx(s2_c38ed_ff);
               else
                  s3_sum_in = sx(s2_c6e_ff) - sx(s2_c8ed_ff);
            end
            DIST_TWO: begin
               if (s2_tag_ff.homo_o) s3_sum_in = sx(s2_c12ed_ff);
            end
            default: s3_sum_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_tag_ff <= s2_tag_ff;
         s3_sum_ff <= s3_sum_in;
      end
   end

   // stage 4: clamp into the response register
   always_comb begin
      if (s3_sum_ff[SUM_W-1])       s4_lh_in = '0;
      else if (s3_sum_ff > sx(ONE)) s4_lh_in = ONE;
      else                          s4_lh_in = s3_sum_ff[VAL_W-1:0];
   end

   logic [IDX_W-1:0] s4_k_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_lh_ff <= s4_lh_in;
         s4_k_ff  <= s3_tag_ff.k;
      end
   end

   assign rsp.valid          = s4_valid_ff;
   assign rsp.genotype_index = s4_k_ff;
   assign rsp.likelihood     = s4_lh_ff;
   assign rsp.last           = s4_k_ff == LAST_IDX;

`ifndef SYNTHESIS
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.last |-> rsp.genotype_index == LAST_IDX)
      else $error("last flag on a response other than the final index");

   a_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.likelihood <= ONE)
      else $error("likelihood above one");

   a_start: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> busy_ff && k_ff == '0)
      else $error("accepted request did not restart the issue counter");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && !rsp.ready |=> s4_valid_ff)
      else $error("stalled response dropped");
`endif

endmodule

### tb/genotype_error_tip_likelihood_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for genotype_error_tip_likelihood: ten Q1.16 likelihoods per
// genotype mask, predicted in fixed point and checked in order under random stalls.
// Depends on gtlik_pkg, gtlik_if and the block itself.
module genotype_error_tip_likelihood_tb;
   import gtlik_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] genotype_index;
      logic [VAL_W-1:0] likelihood;
      logic             last;
   } likelihood_rsp_type;

   localparam longint FX_ONE           = longint'(1) << FRAC_BITS;
   localparam longint FX_TWO           = longint'(1) << (FRAC_BITS + 1);
   localparam longint K_THIRD          = (FX_TWO + 3) / 6;
   localparam longint K_SIXTH          = (FX_TWO + 6) / 12;
   localparam longint K_EIGHTH         = (FX_TWO + 8) / 16;
   localparam longint K_THREE_EIGHTHS  = (3 * FX_TWO + 8) / 16;
   localparam longint K_TWELFTH        = (FX_TWO + 12) / 24;
   localparam longint K_HALF           = (FX_TWO + 2) / 4;
   localparam int     QUIET_LIMIT      = 2000;
   localparam int     SETTLE_CYCLES    = 12;
   localparam int     LONG_HOLD_CYCLES = 120;
   localparam int     REPORT_LIMIT     = 10;
   localparam int     PHASE_COUNT      = 6;
   localparam int     PHASE_REQUESTS   = 49;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LOW = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_TOP = '1;
   localparam logic [MASK_W-1:0]    MASK_ANY       = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gtlik_req_if req_bus ();
   gtlik_rsp_if rsp_bus ();
   gtlik_csr_if csr_bus ();

   genotype_error_tip_likelihood DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   logic [MASK_W-1:0]  pending_masks[$];
   likelihood_rsp_type expected_likelihoods[$];
   logic [RATE_W-1:0]  error_rate_copy;
   logic [RATE_W-1:0]  dropout_copy;
   int                 sender_idle_pct;
   int                 receiver_idle_pct;
   bit                 long_hold_armed;
   bit                 long_hold_taken;
   int                 hold_left;
   int                 failures;
   int                 quiet_cycles;
   int                 phase;
   int                 n;
   logic [RATE_W-1:0]  phase_error;
   logic [RATE_W-1:0]  phase_dropout;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint q_product(input longint a, input longint b);
      return (a * b) >>> FRAC_BITS;
   endfunction

   // two alleles of a genotype, A=0 C=1 G=2 T=3
   function automatic logic [3:0] alleles_of(input int g);
      case (g)
         0: return 4'b0000;
         1: return 4'b0101;
         2: return 4'b1010;
         3: return 4'b1111;
         4: return 4'b0001;
         5: return 4'b0010;
         6: return 4'b0011;
         7: return 4'b0110;
         8: return 4'b0111;
         default: return 4'b1011;
      endcase
   endfunction

   function automatic int letters_apart(input int x, input int y);
      logic [3:0] p;
      logic [3:0] q;
      int         shared;
      p = alleles_of(x);
      q = alleles_of(y);
      if (p[3:2] == q[3:2]) begin
         shared = 1 + int'(p[1:0] == q[1:0]);
      end else if (p[3:2] == q[1:0]) begin
         shared = 1 + int'(p[1:0] == q[3:2]);
      end else begin
         shared = int'(p[1:0] == q[3:2] || p[1:0] == q[1:0]);
      end
      return 2 - shared;
   endfunction

   function automatic logic [VAL_W-1:0] tip_likelihood(input int obs, input int k);
      longint e;
      longint d;
      longint ed;
      longint v;
      int     apart;
      bit     homo_o;
      bit     homo_k;
      e      = longint'(error_rate_copy);
      d      = longint'(dropout_copy);
      ed     = q_product(e, d);
      apart  = letters_apart(obs, k);
      homo_o = obs < HOMO_COUNT;
      homo_k = k < HOMO_COUNT;
      if (apart == 0) begin
         if (homo_o) v = FX_ONE - e + q_product(K_HALF, ed);
         else v = q_product(FX_ONE - d, FX_ONE - e) + q_product(K_TWELFTH, ed);
      end else if (apart == 1) begin
         if (homo_k) v = q_product(K_TWELFTH, ed) + q_product(K_THIRD, q_product(FX_ONE - d, e));
         else if (homo_o) v = q_product(K_HALF, d) + q_product(K_SIXTH, e)
                              - q_product(K_THREE_EIGHTHS, ed);
         else v = q_product(K_SIXTH, e) - q_product(K_EIGHTH, ed);
      end else begin
         v = homo_o ? q_product(K_TWELFTH, ed) : 0;
      end
      if (v < 0) v = 0;
      if (v > FX_ONE) v = FX_ONE;
      return VAL_W'(v);
   endfunction

   function automatic void predict_likelihoods(input logic [MASK_W-1:0] mask);
      bit                 uninformative;
      int                 obs;
      likelihood_rsp_type r;
      uninformative = (mask == '0) || (mask == MASK_ANY);
      obs = 0;
      for (int i = GENOTYPE_COUNT - 1; i >= 0; i--) begin
         if (mask[i]) obs = i;
      end
      for (int k = 0; k < GENOTYPE_COUNT; k++) begin
         r.genotype_index = IDX_W'(k);
         r.likelihood     = uninformative ? VAL_W'(FX_ONE) : tip_likelihood(obs, k);
         r.last           = (k == GENOTYPE_COUNT - 1);
         expected_likelihoods = {expected_likelihoods, r};
      end
   endfunction

   function automatic void queue_mask(input logic [MASK_W-1:0] mask);
      pending_masks = {pending_masks, mask};
   endfunction

   function automatic logic [MASK_W-1:0] random_mask();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return ($urandom_range(0, 1) != 0) ? MASK_ANY : '0;
      if (pick < 40) return MASK_W'(1) << $urandom_range(0, GENOTYPE_COUNT - 1);
      if (pick < 55) begin
         n = $urandom_range(0, GENOTYPE_COUNT - 1);
         return (MASK_W'(1) << n) | (MASK_W'($urandom) & (MASK_ANY << n));
      end
      return MASK_W'($urandom);
   endfunction

   // request side
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid         <= 1'b0;
         req_bus.genotype_mask <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) predict_likelihoods(req_bus.genotype_mask);
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_masks.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_bus.valid         <= 1'b1;
               req_bus.genotype_mask <= pending_masks.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready   <= 1'b0;
         hold_left       <= 0;
         long_hold_taken <= 1'b0;
      end else if (long_hold_armed && !long_hold_taken) begin
         long_hold_taken <= 1'b1;
         hold_left       <= LONG_HOLD_CYCLES;
         rsp_bus.ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      likelihood_rsp_type want;
      likelihood_rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.genotype_index = rsp_bus.genotype_index;
         got.likelihood     = rsp_bus.likelihood;
         got.last           = rsp_bus.last;
         if (expected_likelihoods.size() == 0) begin
            if (failures < REPORT_LIMIT)
               $display("unexpected response: index %0d likelihood %0d last %0b",
                        got.genotype_index, got.likelihood, got.last);
            failures++;
         end else begin
            want = expected_likelihoods.pop_front();
            if (got !== want) begin
               if (failures < REPORT_LIMIT)
                  $display("mismatch: expected index %0d likelihood %0d last %0b, got %0d %0d %0b",
                           want.genotype_index, want.likelihood, want.last,
                           got.genotype_index, got.likelihood, got.last);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
                   || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [RATE_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_SEQ_ERROR_RATE) error_rate_copy = value;
      else if (idx == CSR_DROPOUT_RATE) dropout_copy = value;
   endtask

   task automatic drain_requests();
      @(negedge clock);
      while (pending_masks.size() != 0 || req_bus.valid || expected_likelihoods.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.genotype_mask = '0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;
      error_rate_copy       = '0;
      dropout_copy          = '0;
      long_hold_armed       = 1'b0;
      failures              = 0;
      sender_idle_pct       = 20;
      receiver_idle_pct     = 46;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_register(CSR_SEQ_ERROR_RATE, 16'h2345);
      write_register(CSR_DROPOUT_RATE, 16'h1a2b);
      write_register(CSR_UNUSED_LOW, 16'hffff);
      write_register(CSR_UNUSED_TOP, 16'h5555);
      queue_mask('0);
      queue_mask(MASK_ANY);
      for (int i = 0; i < GENOTYPE_COUNT; i++) queue_mask(MASK_W'(1) << i);
      queue_mask(10'h3fe);
      queue_mask(10'h300);
      queue_mask(10'h2aa);
      queue_mask(10'h155);
      queue_mask(10'h0f0);
      drain_requests();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         sender_idle_pct   = (phase < 2) ? 20 : (phase < 4) ? 46 : 0;
         receiver_idle_pct = (phase < 2) ? 46 : (phase < 4) ? 20 : 0;
         case (phase)
            0: begin phase_error = '0; phase_dropout = '0; end
            1: begin phase_error = '1; phase_dropout = '1; end
            2: begin phase_error = '0; phase_dropout = '1; end
            3: begin phase_error = '1; phase_dropout = '0; end
            4: begin phase_error = RATE_W'($urandom); phase_dropout = RATE_W'($urandom); end
            default: begin
               phase_error   = RATE_W'($urandom_range(0, 16'h2000));
               phase_dropout = RATE_W'($urandom_range(0, 16'h4000));
            end
         endcase
         write_register(CSR_SEQ_ERROR_RATE, phase_error);
         write_register(CSR_DROPOUT_RATE, phase_dropout);
         if (phase == 3) write_register(CSR_IDX_W'($urandom_range(2, 14)), RATE_W'($urandom));
         @(negedge clock);
         for (int i = 0; i < PHASE_REQUESTS; i++) queue_mask(random_mask());
         // stall the responses long enough to back the block up
         if (phase == 4) long_hold_armed = 1'b1;
         drain_requests();
      end

      failures += expected_likelihoods.size();
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/gtlik_pkg.sv
hw/rtl/gtlik_if.sv
hw/rtl/genotype_error_tip_likelihood.sv
tb/genotype_error_tip_likelihood_tb.sv
